// ===== sv/pcsa_pkg.sv =====
// Shared types and constants for the PCSA distinct count sketch.
package pcsa_pkg;

    localparam int MAX_MAPS    = 64;
    localparam int HASH_BYTES  = 16;
    localparam int STORE_BYTES = MAX_MAPS * (HASH_BYTES - 1);
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int MAP_W       = $clog2(MAX_MAPS + 1);
    localparam int IDX_W       = $clog2(MAX_MAPS);
    localparam int FRAC_BITS   = 16;
    localparam int DIV_W       = 32;

    localparam logic [30:0] EST_MAX = 31'h7FFF_FFFF;
    localparam logic [63:0] EST_K64 = ((64'd1 << 30) * 64'd100000 + 64'd38675) / 64'd77351;
    localparam logic [31:0] EST_K   = EST_K64[31:0];

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_DIV,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_Q_SCAN,
        ST_Q_DRAIN,
        ST_Q_LOAD,
        ST_Q_DIV,
        ST_Q_EXP,
        ST_Q_SCALE,
        ST_Q_MULM,
        ST_Q_FIN,
        ST_DONE
    } state_t;

    typedef logic [31:0] exp_tab_t [FRAC_BITS + 1];

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = val;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    tab;
        logic [63:0] t;
        t      = 64'd1 << 31;
        tab[0] = t[31:0];
        for (int k = 1; k <= FRAC_BITS; k++) begin
            t      = isqrt64(t << 30);
            tab[k] = t[31:0];
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== sv/pcsa_distinct_count_sketch.sv =====
// PCSA distinct count sketch: byte store, add, query and clear sequencer.
// Bitmaps live in a 960 x 8 synchronous RAM with one write and one read
// port. After reset the block sweeps the RAM to zero before it takes a word.
// An add runs a 32-step remainder unit that picks the bitmap while the hash
// bytes are scanned, then one read-modify-write of a byte; when the remaining
// bytes are all zero there is no write. A clear makes one RAM write per byte.
// A query reads every byte of the active maps once, then runs 32 divider
// steps, up to 16 exponent multiplies and the scaling steps. One word is in
// work at a time; a result waits in the output register while the next word
// is taken.
module pcsa_distinct_count_sketch
    import pcsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [63:0] s_hash_low,
    input  logic [63:0] s_hash_high,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_estimate,
    output logic [12:0] m_position_sum
);

    state_t state_reg, state_next;

    logic [2:0]   key_bytes_reg;
    logic [6:0]   map_count_reg;
    logic [2:0]   kb;
    logic [3:0]   rb;
    logic [MAP_W-1:0] m_eff;

    logic [7:0]   mem [STORE_BYTES];
    logic [7:0]   mem_q;
    logic         mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]   mem_wdata;

    logic [1:0]   cmd_reg;
    logic [127:0] hash_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic [DIV_W-1:0] div_reg;
    logic [6:0]   rem_reg;
    logic [4:0]   cnt_reg;
    logic [7:0]   rem_sh;
    logic         rem_ge;

    logic [3:0]   scan_reg;
    logic         hit_reg;
    logic [3:0]   hit_byte_reg;
    logic [7:0]   hit_mask_reg;
    logic [4:0]   byte_sel;
    logic [7:0]   scan_byte;
    logic [ADDR_W-1:0] add_addr, add_addr_reg;

    logic [ADDR_W-1:0] qaddr_reg;
    logic [3:0]   pbyte_reg;
    logic [MAP_W-1:0] map_reg;
    logic         p1_valid_reg, p1_last_reg;
    logic [3:0]   p1_pbyte_reg;
    logic         found_reg;
    logic [6:0]   pos_reg;
    logic [12:0]  sum_reg;
    logic         q_last;

    logic [31:0]  acc_reg;
    logic [63:0]  exp_prod;
    logic [31:0]  y_reg;
    logic [63:0]  y_prod;
    logic [38:0]  a_reg;
    logic [12:0]  q_val;
    logic [12:0]  sh_up;
    logic [69:0]  wide_up;
    logic [38:0]  wide_dn;
    logic [30:0]  est_calc;
    logic [30:0]  est_reg;

    logic         m_valid_reg;
    logic [30:0]  m_est_reg;
    logic [12:0]  m_sum_reg;
    logic         out_free;

    function automatic logic [2:0] low_zero(input logic [7:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!v[i]) r = 3'(i);
        end
        return r;
    endfunction

    always_comb begin
        if (key_bytes_reg == 3'd0)     kb = 3'd1;
        else if (key_bytes_reg > 3'd4) kb = 3'd4;
        else                           kb = key_bytes_reg;
        rb = 4'(5'd16 - {2'b0, kb});
        if (map_count_reg == 7'd0)                   m_eff = MAP_W'(1);
        else if (map_count_reg > 7'(MAX_MAPS))       m_eff = MAP_W'(MAX_MAPS);
        else                                         m_eff = MAP_W'(map_count_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_bytes_reg <= 3'd1;
            map_count_reg <= 7'(MAX_MAPS);
        end else if (cfg_we) begin
            if (cfg_index == 1'b0) key_bytes_reg <= cfg_data[2:0];
            else                   map_count_reg <= cfg_data;
        end
    end

    // byte store
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        mem_q <= mem[mem_raddr];
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    assign rem_sh = {rem_reg, div_reg[DIV_W-1]};
    assign rem_ge = (rem_sh >= 8'(m_eff));

    assign byte_sel  = 5'({2'b0, kb}) + 5'(scan_reg);
    assign scan_byte = hash_reg[8*byte_sel[3:0] +: 8];
    assign add_addr  = ADDR_W'(rb * rem_reg[IDX_W-1:0]) + ADDR_W'(hit_byte_reg);

    assign q_last = (pbyte_reg == rb - 4'd1) && (map_reg == m_eff - MAP_W'(1));

    assign exp_prod = 64'(acc_reg) * 64'(EXP_TAB[cnt_reg + 5'd1]) + (64'd1 << 29);
    assign y_prod   = 64'(acc_reg) * 64'(EST_K) + (64'd1 << 29);
    assign q_val    = div_reg[28:16];

    always_comb begin
        sh_up    = q_val - 13'd14;
        wide_up  = 70'(a_reg) << sh_up[4:0];
        wide_dn  = a_reg >> (4'd14 - q_val[3:0]);
        est_calc = '0;
        if (q_val >= 13'd14) begin
            if (a_reg == '0)                                      est_calc = '0;
            else if (sh_up >= 13'd31 || wide_up[69:31] != '0)     est_calc = EST_MAX;
            else                                                  est_calc = wide_up[30:0];
        end else begin
            if (wide_dn[38:31] != '0) est_calc = EST_MAX;
            else                      est_calc = wide_dn[30:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(STORE_BYTES - 1))
                    state_next = (cmd_reg == CMD_CLEAR) ? ST_DONE : ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_command)
                        CMD_ADD:   state_next = ST_ADD_DIV;
                        CMD_QUERY: state_next = ST_Q_SCAN;
                        CMD_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_ADD_DIV: if (cnt_reg == 5'd31) state_next = hit_reg ? ST_ADD_RD : ST_DONE;
            ST_ADD_RD:  state_next = ST_ADD_WR;
            ST_ADD_WR:  state_next = ST_DONE;
            ST_Q_SCAN:  if (q_last) state_next = ST_Q_DRAIN;
            ST_Q_DRAIN: state_next = ST_Q_LOAD;
            ST_Q_LOAD:  state_next = ST_Q_DIV;
            ST_Q_DIV:   if (cnt_reg == 5'd31) state_next = ST_Q_EXP;
            ST_Q_EXP:   if (cnt_reg == 5'd15) state_next = ST_Q_SCALE;
            ST_Q_SCALE: state_next = ST_Q_MULM;
            ST_Q_MULM:  state_next = ST_Q_FIN;
            ST_Q_FIN:   state_next = ST_DONE;
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // RAM port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        mem_raddr = qaddr_reg;
        case (state_reg)
            ST_CLEAR: mem_we = 1'b1;
            ST_ADD_RD: mem_raddr = add_addr;
            ST_ADD_WR: begin
                mem_we    = 1'b1;
                mem_waddr = add_addr_reg;
                mem_wdata = mem_q | hit_mask_reg;
            end
            default: mem_raddr = qaddr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            cmd_reg      <= CMD_NONE;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) m_valid_reg <= 1'b1;
            else if (m_ready)                     m_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg      <= s_command;
                        hash_reg     <= {s_hash_high, s_hash_low};
                        clr_addr_reg <= '0;
                        cnt_reg      <= '0;
                        rem_reg      <= '0;
                        scan_reg     <= '0;
                        hit_reg      <= 1'b0;
                        qaddr_reg    <= '0;
                        pbyte_reg    <= '0;
                        map_reg      <= '0;
                        found_reg    <= 1'b0;
                        sum_reg      <= '0;
                        case (kb)
                            3'd1:    div_reg <= {24'b0, s_hash_low[7:0]};
                            3'd2:    div_reg <= {16'b0, s_hash_low[15:0]};
                            3'd3:    div_reg <= {8'b0, s_hash_low[23:0]};
                            default: div_reg <= s_hash_low[31:0];
                        endcase
                    end
                end
                ST_ADD_DIV, ST_Q_DIV: begin
                    rem_reg <= rem_ge ? 7'(rem_sh - 8'(m_eff)) : rem_sh[6:0];
                    div_reg <= {div_reg[DIV_W-2:0], rem_ge};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (state_reg == ST_ADD_DIV && !hit_reg && scan_reg < rb) begin
                        scan_reg <= scan_reg + 4'd1;
                        if (scan_byte != 8'd0) begin
                            hit_reg      <= 1'b1;
                            hit_byte_reg <= scan_reg;
                            hit_mask_reg <= scan_byte & (~scan_byte + 8'd1);
                        end
                    end
                    if (state_reg == ST_Q_DIV) acc_reg <= 32'd1 << 30;
                end
                ST_ADD_RD: add_addr_reg <= add_addr;
                ST_Q_SCAN: begin
                    p1_valid_reg <= 1'b1;
                    p1_pbyte_reg <= pbyte_reg;
                    p1_last_reg  <= (pbyte_reg == rb - 4'd1);
                    qaddr_reg    <= qaddr_reg + ADDR_W'(1);
                    if (pbyte_reg == rb - 4'd1) begin
                        pbyte_reg <= '0;
                        map_reg   <= map_reg + MAP_W'(1);
                    end else begin
                        pbyte_reg <= pbyte_reg + 4'd1;
                    end
                end
                ST_Q_LOAD: begin
                    div_reg <= {3'b0, sum_reg, 16'b0};
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end
                ST_Q_EXP: begin
                    if (div_reg[5'd15 - cnt_reg]) acc_reg <= exp_prod[61:30];
                    cnt_reg <= cnt_reg + 5'd1;
                end
                ST_Q_SCALE: y_reg <= y_prod[61:30];
                ST_Q_MULM:  a_reg <= 39'(y_reg) * 39'(m_eff);
                ST_Q_FIN:   est_reg <= est_calc;
                ST_DONE: begin
                    if (out_free) begin
                        if (cmd_reg == CMD_QUERY) begin
                            m_est_reg <= est_reg;
                            m_sum_reg <= sum_reg;
                        end else begin
                            m_est_reg <= '0;
                            m_sum_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase

            if (state_reg == ST_Q_DRAIN) p1_valid_reg <= 1'b0;
            if (p1_valid_reg) begin
                if (p1_last_reg) begin
                    found_reg <= 1'b0;
                    if (found_reg)
                        sum_reg <= sum_reg + 13'(pos_reg);
                    else if (mem_q != 8'hFF)
                        sum_reg <= sum_reg + 13'({p1_pbyte_reg, low_zero(mem_q)});
                    else
                        sum_reg <= sum_reg + 13'({rb, 3'b0});
                end else if (!found_reg && mem_q != 8'hFF) begin
                    found_reg <= 1'b1;
                    pos_reg   <= {p1_pbyte_reg, low_zero(mem_q)};
                end
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_estimate     = m_est_reg;
    assign m_position_sum = m_sum_reg;

    a_we_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_ADD_WR))
        else $error("store written outside clear or add");

    a_scan_map: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_Q_SCAN |-> map_reg < m_eff)
        else $error("query walk beyond active maps");

    a_hit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD_RD) |-> (hit_reg && hit_byte_reg < rb && $onehot(hit_mask_reg)))
        else $error("add target byte out of bitmap");

    a_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg != ST_IDLE)
        else $error("accepted word not started");

endmodule

// ===== tb/sv/pcsa_checker.sv =====
// Checker for the PCSA sketch: tracks the bitmap store, predicts each result word and compares.
`timescale 1ns / 1ps
module pcsa_checker
    import pcsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [63:0] s_hash_low,
    input  logic [63:0] s_hash_high,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [30:0] m_estimate,
    input  logic [12:0] m_position_sum,
    output int          outstanding,
    output int          fail_count
);

    typedef struct packed {
        logic [30:0] estimate;
        logic [12:0] position_sum;
    } sketch_result_t;

    logic [7:0]     bitmaps [STORE_BYTES];
    logic [2:0]     key_reg;
    logic [6:0]     maps_reg;
    sketch_result_t result_q [$];

    assign outstanding = result_q.size();

    function automatic int key_len();
        return (key_reg == 0) ? 1 : (key_reg > 4) ? 4 : int'(key_reg);
    endfunction

    function automatic int map_total();
        return (maps_reg == 0) ? 1 : (maps_reg > MAX_MAPS) ? MAX_MAPS : int'(maps_reg);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] val);
        logic [63:0] rem, root, probe;
        rem   = val;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem && probe != 0) probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic void mark_hash(input logic [127:0] h);
        int          kb, rb, m, idx;
        logic [63:0] key;
        kb  = key_len();
        rb  = HASH_BYTES - kb;
        m   = map_total();
        key = h[63:0] & ((64'd1 << (8 * kb)) - 1);
        idx = int'(key % m);
        for (int p = 0; p < 8 * rb; p++) begin
            if (h[8 * kb + p]) begin
                bitmaps[rb * idx + p / 8][p % 8] = 1'b1;
                return;
            end
        end
    endfunction

    function automatic sketch_result_t estimate_count();
        sketch_result_t res;
        int             rb, m, pos;
        logic [63:0]    s, q, r, frac, acc, t, kc, y, a, est, sh;
        rb = HASH_BYTES - key_len();
        m  = map_total();
        s  = 0;
        for (int i = 0; i < m; i++) begin
            pos = 8 * rb;
            for (int p = 8 * rb - 1; p >= 0; p--)
                if (!bitmaps[rb * i + p / 8][p % 8]) pos = p;
            s += pos;
        end
        q    = s / m;
        r    = s % m;
        frac = (r << FRAC_BITS) / m;
        acc  = 64'd1 << 30;
        t    = 64'd1 << 31;
        for (int k = 1; k <= FRAC_BITS; k++) begin
            t = int_sqrt(t << 30);
            if (frac[FRAC_BITS - k])
                acc = (acc * t + (64'd1 << 29)) >> 30;
        end
        kc = ((64'd1 << 30) * 64'd100000 + 64'd38675) / 64'd77351;
        y  = (acc * kc + (64'd1 << 29)) >> 30;
        a  = y * m;
        if (q >= 14) begin
            sh = q - 14;
            if (a == 0) est = 0;
            else if (sh >= 31 || a > (64'h7FFF_FFFF >> sh)) est = 64'h7FFF_FFFF;
            else est = a << sh;
        end else begin
            est = a >> (14 - q);
            if (est > 64'h7FFF_FFFF) est = 64'h7FFF_FFFF;
        end
        res.estimate     = est[30:0];
        res.position_sum = (s > 8191) ? 13'd8191 : s[12:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        sketch_result_t want;
        if (!aresetn) begin
            foreach (bitmaps[i]) bitmaps[i] = 8'h00;
            key_reg  <= 3'd1;
            maps_reg <= 7'd64;
            result_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == 1'b0) key_reg <= cfg_data[2:0];
                else maps_reg <= cfg_data;
            end
            if (s_valid && s_ready) begin
                want = '0;
                case (cmd_t'(s_command))
                    CMD_ADD:   mark_hash({s_hash_high, s_hash_low});
                    CMD_QUERY: want = estimate_count();
                    CMD_CLEAR: foreach (bitmaps[i]) bitmaps[i] = 8'h00;
                    default:   ;
                endcase
                result_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result word est %0d sum %0d",
                             $time, m_estimate, m_position_sum);
                    fail_count <= fail_count + 1;
                end else begin
                    want = result_q.pop_front();
                    if (want.estimate !== m_estimate || want.position_sum !== m_position_sum) begin
                        $display("%0t: mismatch estimate exp %0d got %0d, position_sum exp %0d got %0d",
                                 $time, want.estimate, m_estimate, want.position_sum, m_position_sum);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the PCSA sketch: clock, reset, stimulus, config phases and verdict.
`timescale 1ns / 1ps
module tb_top;
    import pcsa_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [6:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = CMD_NONE;
    logic [63:0] s_hash_low = '0;
    logic [63:0] s_hash_high = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [30:0] m_estimate;
    logic [12:0] m_position_sum;
    int          outstanding, fail_count;
    int          cycles = 0;
    int          stall_cnt = 0;
    bit          no_gaps = 0;
    int          key_now = 1;
    logic [2:0]  kb_set [8] = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd4};
    logic [6:0]  mc_set [8] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd17, 7'd64, 7'd65, 7'd3};

    localparam int CYCLE_LIMIT = 4000000;

    always #5 aclk = ~aclk;

    pcsa_distinct_count_sketch dut (.*);

    pcsa_checker chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** pcsa_distinct_count_sketch: FAILED **");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver stall pattern, with stretches of no stall
    always @(posedge aclk) begin
        int hold;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            stall_cnt <= 0;
        end else if (no_gaps) begin
            m_ready   <= 1'b1;
            stall_cnt <= 0;
        end else if (stall_cnt > 0) begin
            m_ready   <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end else begin
            hold = gap_len();
            stall_cnt <= hold;
            m_ready   <= (hold == 0);
        end
    end

    task automatic send(input cmd_t cmd, input logic [63:0] lo, input logic [63:0] hi);
        int g;
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_hash_low  <= lo;
        s_hash_high <= hi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic drain_and_config(input logic [2:0] kb, input logic [6:0] mc);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= 1'b0;
        cfg_data  <= {4'd0, kb};
        @(posedge aclk);
        cfg_index <= 1'b1;
        cfg_data  <= mc;
        @(posedge aclk);
        cfg_we <= 1'b0;
        key_now = (kb == 0) ? 1 : (kb > 4) ? 4 : int'(kb);
    endtask

    // add word with first set bit after the key chosen, none, or all random
    task automatic send_add();
        logic [127:0] h;
        int           kbits, pos, r;
        h     = {$urandom, $urandom, $urandom, $urandom};
        kbits = 8 * key_now;
        r     = $urandom_range(0, 99);
        if (r < 3) begin
            for (int b = kbits; b < 128; b++) h[b] = 1'b0;
        end else if (r < 70) begin
            pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 128 - kbits - 1)
                                              : $urandom_range(0, 12);
            for (int b = kbits; b < kbits + pos; b++) h[b] = 1'b0;
            h[kbits + pos] = 1'b1;
        end
        send(CMD_ADD, h[63:0], h[127:64]);
    endtask

    task automatic random_phase(input int count);
        int r;
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 85) send_add();
            else if (r < 93) send(CMD_QUERY, {$urandom, $urandom}, {$urandom, $urandom});
            else if (r < 96) send(CMD_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
            else send(CMD_NONE, {$urandom, $urandom}, {$urandom, $urandom});
            if (n == count / 2) no_gaps = !no_gaps;
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send(CMD_QUERY, '0, '0);
        send(CMD_ADD, '0, '0);
        send(CMD_ADD, 64'h0000_0000_0000_00FF, '0);
        send(CMD_ADD, '1, '1);
        send(CMD_ADD, 64'h0000_0000_0000_0005, 64'h8000_0000_0000_0000);
        send(CMD_ADD, 64'h0000_0000_0000_0100, '0);
        send(CMD_QUERY, '1, '1);
        send(CMD_NONE, '1, '1);
        send(CMD_CLEAR, '1, '1);
        send(CMD_QUERY, '0, '0);
        drain_and_config(3'd4, 7'd1);
        for (int p = 0; p < 96; p += 19)
            send(CMD_ADD, '0, 64'd1 << p % 64 + (p >= 64 ? 0 : 0));
        send(CMD_ADD, 64'hFFFF_FFFF_0000_0000, '0);
        send(CMD_QUERY, '0, '0);
        drain_and_config(3'd0, 7'd0);
        send(CMD_ADD, 64'h0000_0000_0000_0200, '0);
        send(CMD_QUERY, '0, '0);

        for (int ph = 0; ph < 8; ph++) begin
            drain_and_config(kb_set[ph], mc_set[ph]);
            random_phase(ph == 1 ? 300 : 130);
            send(CMD_QUERY, '0, '0);
        end

        no_gaps = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** pcsa_distinct_count_sketch: PASSED **");
        end else begin
            $display("** pcsa_distinct_count_sketch: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/pcsa_pkg.sv
sv/pcsa_distinct_count_sketch.sv
tb/sv/pcsa_checker.sv
tb/sv/tb_top.sv
